[rtl/ssdh_pkg.sv]
// Package for the sample statistics / density histogram block.
// Holds payload structs, widths and register codes; no dependencies.
package ssdh_pkg;

  localparam int unsigned MaxSamplesDef = 1024;
  localparam int unsigned MaxBinsDef    = 62;
  localparam int unsigned SlotCount     = 64;
  localparam int unsigned SlotW         = 6;
  localparam int unsigned CntW          = 11;
  localparam int unsigned SumW          = 42;
  localparam int unsigned SqSumW        = 58;
  localparam logic [5:0]  BinResetVal   = 6'd50;
  localparam logic        RegBinCount   = 1'b0;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic               is_stats;
    logic signed [31:0] mean;
    logic [47:0]        variance;
    logic               overflow;
    logic signed [31:0] bin_key;
    logic [10:0]        bin_samples;
    logic [16:0]        density;
    logic               last_result;
  } out_item_t;

  // Unsigned restoring divider request
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

endpackage

[rtl/ssdh_div.sv]
// Iterative unsigned divider, one quotient bit per cycle.
// Depends on ssdh_pkg for the request struct.
module ssdh_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssdh_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic [63:0]       quot_o
);
  import ssdh_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[63]};
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num;
      den_d = req_i.den;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      // shift one numerator bit in, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = 64'(trial - {1'b0, den_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  // busy from the next cycle after a start until the quotient is ready
  assign busy_o = (cnt_q != 7'd0);
  assign quot_o = quo_q;
endmodule

[rtl/sample_stats_density_histogram.sv]
// Sample statistics and density histogram top level; uses ssdh_pkg and ssdh_div.
// Flow: samples load while the block is idle. After the last one the statistics
// take four divides on the shared divider, each stored sample one divide to
// bin, each non-empty bin one divide (empty slots are skipped), then a bin
// clear over all slots. Output stalls hold the result run; input stalls till done.
// Reset clears control and runs the bin clear; the store is not cleared.
module sample_stats_density_histogram #(
  parameter int unsigned MAX_SAMPLES = ssdh_pkg::MaxSamplesDef,
  parameter int unsigned MAX_BINS    = ssdh_pkg::MaxBinsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssdh_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssdh_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ssdh_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);

  localparam logic [3:0] S_LOAD = 4'd0, S_MEAN = 4'd1, S_MSQ = 4'd2, S_SQM = 4'd3,
                         S_WID = 4'd4, S_BASE = 4'd5, S_RD = 4'd6, S_IDX = 4'd7,
                         S_BIN = 4'd8, S_STAT = 4'd9, S_SCAN = 4'd10, S_DENS = 4'd11,
                         S_EMIT = 4'd12, S_CLR = 4'd13;

  logic [3:0]  st_q, st_d;
  logic [5:0]  nbset_q;
  logic [NW-1:0] n_q;
  logic signed [SumW-1:0] sum_q;
  logic [SqSumW-1:0] sq_q;
  logic signed [31:0] min_q, max_q;
  logic drop_q;
  logic signed [31:0] mean_q;
  logic [63:0] msq_q;
  logic [63:0] w_q;
  logic signed [32:0] base_q;
  logic [NW-1:0] ptr_q;
  logic [SlotW-1:0] slot_q, last_q;
  logic signed [31:0] key_q;
  logic [CntW-1:0] cnt_q;
  logic out_v_q;
  out_item_t out_q, out_d;
  logic out_ld;
  logic rneg_q;
  logic inc_q, inc_ok;
  logic [SlotW-1:0] inc_slot_q;

  // sample store and bin counter memories
  logic signed [31:0] store_mem [MAX_SAMPLES];
  logic signed [31:0] store_rd_q;
  logic [CntW-1:0] bin_mem [SlotCount];
  logic [CntW-1:0] bin_rd_q;
  logic [SlotW-1:0] bin_ra;

  div_req_t dreq;
  logic dbusy;
  logic [63:0] dq;

  ssdh_div u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(dbusy), .quot_o(dq));

  logic in_acc, cfg_wr, out_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != S_LOAD);
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = {26'd0, nbset_q};
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  logic [5:0] nb;
  always_comb begin
    nb = nbset_q;
    if (nb == 6'd0) nb = 6'd1;
    if (32'(nb) > MAX_BINS) nb = 6'(MAX_BINS);
  end

  logic [31:0] mag_s;
  logic [63:0] sq_s;
  logic full;
  assign mag_s = in_data_i.sample[31] ? 32'(-in_data_i.sample) : in_data_i.sample;
  assign sq_s = mag_s * mag_s;
  assign full = (n_q == NW'(MAX_SAMPLES));

  logic [63:0] sum_abs, range_u, sqm_full, sqm;
  logic [31:0] mean_abs;
  logic [32:0] range_s;
  logic signed [63:0] slot_w;
  logic [31:0] key_w;
  assign sum_abs = sum_q[SumW-1] ? -64'(sum_q) : 64'(sum_q);
  assign mean_abs = mean_q[31] ? 32'(-mean_q) : 32'(mean_q);
  assign range_s = {max_q[31], max_q} - {min_q[31], min_q};
  assign range_u = 64'(range_s);
  assign sqm_full = mean_abs * mean_abs;
  assign sqm = sqm_full >> 16;
  assign slot_w = (rneg_q ? -$signed(dq) : $signed(dq)) - 64'(base_q);
  // only the low 32 bits of the key are kept
  assign key_w = 32'(base_q + 33'(slot_q)) * w_q[31:0];
  assign inc_ok = (slot_w >= 0) && (slot_w <= $signed(64'(MAX_BINS)));

  // sequence the divides, the binning pass, the result run and the bin clear
  always_comb begin
    dreq = '0;
    st_d = st_q;
    unique case (st_q)
      S_LOAD: if (in_acc && in_data_i.last_sample) st_d = S_MEAN;
      S_MEAN: begin
        if (n_q == '0) st_d = S_CLR;
        else begin
          dreq = '{1'b1, sum_abs, 64'(n_q)};
          st_d = S_MSQ;
        end
      end
      S_MSQ: if (!dbusy) begin
        dreq = '{1'b1, 64'(sq_q), 64'(n_q)};
        st_d = S_SQM;
      end
      S_SQM: if (!dbusy) begin
        dreq = '{1'b1, range_u + 64'(nb) - 64'd1, 64'(nb)};
        st_d = S_WID;
      end
      S_WID: if (!dbusy) begin
        dreq = '{1'b1, min_q[31] ? -64'(min_q) : 64'(min_q),
                 (dq == '0) ? 64'd1 : dq};
        st_d = S_BASE;
      end
      S_BASE: if (!dbusy) st_d = S_RD;
      S_RD: begin
        if (ptr_q == n_q) st_d = S_STAT;
        else st_d = S_IDX;
      end
      S_IDX: begin
        dreq = '{1'b1, store_rd_q[31] ? -64'(store_rd_q) : 64'(store_rd_q), w_q};
        st_d = S_BIN;
      end
      S_BIN: if (!dbusy) st_d = S_RD;
      S_STAT: if (!out_v_q || out_acc) st_d = S_SCAN;
      S_SCAN: if (bin_rd_q != '0) begin
        dreq = '{1'b1, 64'(bin_rd_q) << 16, 64'(n_q)};
        st_d = S_DENS;
      end else if (slot_q == last_q) st_d = S_CLR;
      S_DENS: if (!dbusy) st_d = S_EMIT;
      S_EMIT: if (!out_v_q || out_acc) st_d = (slot_q == last_q) ? S_CLR : S_SCAN;
      S_CLR: if (slot_q == SlotW'(SlotCount - 1)) st_d = S_LOAD;
      default: st_d = S_LOAD;
    endcase
  end

  // bin counter read address: the next slot to look at
  always_comb begin
    unique case (st_q)
      S_BIN:   bin_ra = slot_w[SlotW-1:0];
      S_STAT:  bin_ra = '0;
      S_SCAN:  bin_ra = (bin_rd_q == '0 && slot_q != last_q) ? slot_q + 1'b1 : slot_q;
      S_EMIT:  bin_ra = slot_q + 1'b1;
      default: bin_ra = slot_q;
    endcase
  end

  // build the next result transaction
  assign out_ld = (st_q == S_STAT || st_q == S_EMIT) && (!out_v_q || out_acc);
  always_comb begin
    out_d = '0;
    if (st_q == S_STAT) begin
      out_d.is_stats = 1'b1;
      out_d.mean = mean_q;
      out_d.variance = (msq_q > sqm) ? 48'(msq_q - sqm) : '0;
      out_d.overflow = drop_q;
    end else begin
      out_d.bin_key = key_q;
      out_d.bin_samples = cnt_q;
      out_d.density = 17'(dq);
      out_d.last_result = (slot_q == last_q);
    end
  end

  // store write, bin read-modify-write and clearing pass
  always_ff @(posedge clk_i) begin
    if (in_acc && !full) store_mem[AW'(n_q)] <= in_data_i.sample;
    store_rd_q <= store_mem[AW'(ptr_q)];
    if (st_q == S_CLR) begin
      bin_mem[slot_q] <= '0;
    end else if (inc_q) begin
      bin_mem[inc_slot_q] <= bin_rd_q + 1'b1;
    end
    bin_rd_q <= bin_mem[bin_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; nbset_q <= BinResetVal; n_q <= '0; sum_q <= '0; sq_q <= '0;
      min_q <= 32'sh7fffffff; max_q <= 32'sh80000000; drop_q <= 1'b0;
      mean_q <= '0; msq_q <= '0; w_q <= '0; base_q <= '0; key_q <= '0; cnt_q <= '0;
      out_v_q <= 1'b0; out_q <= '0; ptr_q <= '0; slot_q <= '0; last_q <= '0;
      rneg_q <= 1'b0; inc_q <= 1'b0; inc_slot_q <= '0;
    end else begin
      st_q <= st_d;
      inc_q <= (st_q == S_BIN) && !dbusy && inc_ok;
      if (cfg_wr && paddr == RegBinCount) nbset_q <= pwdata[5:0];
      // load a result or drop the accepted one
      if (out_ld) begin
        out_v_q <= 1'b1;
        out_q <= out_d;
      end else if (out_acc) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        S_LOAD: if (in_acc) begin
          if (full) drop_q <= 1'b1;
          else begin
            n_q <= n_q + 1'b1;
            sum_q <= sum_q + SumW'(in_data_i.sample);
            sq_q <= sq_q + SqSumW'(sq_s >> 16);
            if (in_data_i.sample < min_q) min_q <= in_data_i.sample;
            if (in_data_i.sample > max_q) max_q <= in_data_i.sample;
          end
        end
        S_MSQ: if (!dbusy) mean_q <= sum_q[SumW-1] ? -32'(dq) : 32'(dq);
        S_SQM: if (!dbusy) msq_q <= dq;
        S_WID: if (!dbusy) w_q <= (dq == '0) ? 64'd1 : dq;
        S_BASE: if (!dbusy) begin
          base_q <= min_q[31] ? -33'(dq) : 33'(dq);
          ptr_q <= '0; slot_q <= '0;
        end
        S_RD: if (ptr_q != n_q) ptr_q <= ptr_q + 1'b1;
        S_IDX: rneg_q <= store_rd_q[31];
        S_BIN: if (!dbusy && inc_ok) begin
          inc_slot_q <= slot_w[SlotW-1:0];
          if (slot_w[SlotW-1:0] > last_q) last_q <= slot_w[SlotW-1:0];
        end
        S_STAT: if (out_ld) slot_q <= '0;
        S_SCAN: begin
          if (bin_rd_q != '0) cnt_q <= bin_rd_q;
          else if (slot_q != last_q) slot_q <= slot_q + 1'b1;
          else slot_q <= '0;
        end
        S_DENS: if (!dbusy) key_q <= key_w;
        S_EMIT: if (out_ld) slot_q <= (slot_q == last_q) ? '0 : slot_q + 1'b1;
        S_CLR: begin
          slot_q <= slot_q + 1'b1;
          if (slot_q == SlotW'(SlotCount - 1)) begin
            n_q <= '0; sum_q <= '0; sq_q <= '0; drop_q <= 1'b0; last_q <= '0;
            min_q <= 32'sh7fffffff; max_q <= 32'sh80000000; ptr_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions
  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_SAMPLES)) else $error("count over capacity");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_LOAD) |-> !in_acc) else $error("load while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> out_v_q) else $error("result lost");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> $stable(out_q)) else $error("stalled result changed");

endmodule
